// ===== rtl/mpsq_pkg.sv =====
package mpsq_pkg;

    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 32;
    localparam int CELLS      = MAX_DIM * MAX_DIM;
    localparam int AW         = $clog2(CELLS);
    localparam int IW         = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW         = $clog2(MAX_DIM + 1);
    localparam int PW         = AW + 1;
    localparam int EXP_W      = 31;
    localparam int CFG_W      = 4;
    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(4);

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_CHECK, S_MUL, S_MDRAIN,
        S_COPY, S_CPDRAIN, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
    } t_state;

    typedef enum logic {M_MUL, M_SQ} t_mode;

    // memory port requests from the sequencer
    typedef struct packed {
        logic                  base_we;
        logic [AW-1:0]         base_waddr;
        logic [ELEM_WIDTH-1:0] base_wdata;
        logic [AW-1:0]         base_ra0;
        logic [AW-1:0]         base_ra1;
        logic                  acc_we;
        logic [AW-1:0]         acc_waddr;
        logic [ELEM_WIDTH-1:0] acc_wdata;
        logic [AW-1:0]         acc_ra;
        logic                  scr_we;
        logic [AW-1:0]         scr_waddr;
        logic [ELEM_WIDTH-1:0] scr_wdata;
        logic [AW-1:0]         scr_ra;
    } t_mem_req;

    // registered read data
    typedef struct packed {
        logic [ELEM_WIDTH-1:0] base_rd0;
        logic [ELEM_WIDTH-1:0] base_rd1;
        logic [ELEM_WIDTH-1:0] acc_rd;
        logic [ELEM_WIDTH-1:0] scr_rd;
    } t_mem_rsp;

    // tag that follows one multiply-accumulate down the pipe
    typedef struct packed {
        logic          v;
        logic          first;
        logic          last;
        logic [AW-1:0] dest;
    } t_mac_tag;

    // row-major address with stride n
    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] row,
                                                 input logic [IW-1:0] col,
                                                 input logic [DW-1:0] n);
        logic [PW+DW-1:0] t;
        t = (PW+DW)'(row) * (PW+DW)'(n) + (PW+DW)'(col);
        return t[AW-1:0];
    endfunction

endpackage

// ===== rtl/mpsq_mem.sv =====
module mpsq_mem import mpsq_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    logic [ELEM_WIDTH-1:0] base_mem [CELLS];
    logic [ELEM_WIDTH-1:0] acc_mem  [CELLS];
    logic [ELEM_WIDTH-1:0] scr_mem  [CELLS];

    // base: one write, two reads
    always_ff @(posedge i_clk) begin
        if (i_req.base_we) begin
            base_mem[i_req.base_waddr] <= i_req.base_wdata;
        end
        o_rsp.base_rd0 <= base_mem[i_req.base_ra0];
        o_rsp.base_rd1 <= base_mem[i_req.base_ra1];
    end

    // accumulated power
    always_ff @(posedge i_clk) begin
        if (i_req.acc_we) begin
            acc_mem[i_req.acc_waddr] <= i_req.acc_wdata;
        end
        o_rsp.acc_rd <= acc_mem[i_req.acc_ra];
    end

    // product scratch
    always_ff @(posedge i_clk) begin
        if (i_req.scr_we) begin
            scr_mem[i_req.scr_waddr] <= i_req.scr_wdata;
        end
        o_rsp.scr_rd <= scr_mem[i_req.scr_ra];
    end

endmodule

// ===== rtl/mpsq_seq.sv =====
module mpsq_seq import mpsq_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_W-1:0]             i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [ELEM_WIDTH-1:0] i_element_value,
    input  logic [EXP_W-1:0]             i_exponent,
    input  logic                         i_last_element,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [ELEM_WIDTH-1:0] o_result_value,
    output logic                         o_last_result,
    output t_mem_req                     o_req,
    input  t_mem_rsp                     i_rsp
);

    t_state                r_state, n_state;
    t_mode                 r_mode, n_mode;
    logic [CFG_W-1:0]      r_dim;
    logic [PW-1:0]         r_pos, n_pos;
    logic [EXP_W-1:0]      r_exp, n_exp;
    logic [IW-1:0]         r_i, n_i, r_j, n_j, r_k, n_k;
    t_mac_tag              r_p1, n_p1, r_p2;
    logic [ELEM_WIDTH-1:0] r_prod, r_sum, mac_sum;
    logic [2*ELEM_WIDTH-1:0] full_prod;
    logic                  r_cp_v, n_cp_v;
    logic [AW-1:0]         r_cp_addr, n_cp_addr;
    logic                  r_ovalid, n_ovalid;
    logic [ELEM_WIDTH-1:0] r_oval;
    logic                  r_olast;
    logic [DW-1:0]         dim_n;
    logic [IW-1:0]         nm1;
    logic [PW+DW-1:0]      cells;
    logic                  j_end, i_end, k_end;

    // active dimension: 0 acts as 1, above MAX_DIM clamps
    always_comb begin
        if (r_dim == '0) begin
            dim_n = DW'(1);
        end else if (32'(r_dim) > MAX_DIM) begin
            dim_n = DW'(MAX_DIM);
        end else begin
            dim_n = DW'(r_dim);
        end
        nm1   = IW'(dim_n - DW'(1));
        cells = (PW+DW)'(dim_n) * (PW+DW)'(dim_n);
        i_end = (r_i == nm1);
        j_end = (r_j == nm1);
        k_end = (r_k == nm1);
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (i_cfg_we) begin
            r_dim <= i_cfg_wdata;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_mode   <= M_MUL;
            r_pos    <= '0;
            r_exp    <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_p1     <= '0;
            r_p2     <= '0;
            r_cp_v   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_exp    <= n_exp;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_p1     <= n_p1;
            r_p2     <= r_p1;
            r_cp_v   <= n_cp_v;
            r_ovalid <= n_ovalid;
        end
    end

    // MAC datapath: operand regs in memory, product, then accumulate
    assign full_prod = (2*ELEM_WIDTH)'((r_mode == M_SQ) ? i_rsp.base_rd0 : i_rsp.acc_rd)
                     * (2*ELEM_WIDTH)'(i_rsp.base_rd1);
    assign mac_sum   = (r_p2.first ? '0 : r_sum) + r_prod;

    always_ff @(posedge i_clk) begin
        r_cp_addr <= n_cp_addr;
        if (r_p1.v) begin
            r_prod <= full_prod[ELEM_WIDTH-1:0];
        end
        if (r_p2.v) begin
            r_sum <= mac_sum;
        end
        if (r_state == S_OUT_LD) begin
            r_oval  <= i_rsp.acc_rd;
            r_olast <= i_end && j_end;
        end
    end

    // next state, counters and memory requests
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_exp     = r_exp;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_p1      = '0;
        n_cp_v    = 1'b0;
        n_cp_addr = r_cp_addr;
        n_ovalid  = r_ovalid;
        o_ready   = 1'b0;
        o_req     = '0;

        o_req.scr_we    = r_p2.v && r_p2.last;
        o_req.scr_waddr = r_p2.dest;
        o_req.scr_wdata = mac_sum;

        unique case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_req.base_we    = ((PW+DW)'(r_pos) < cells);
                    o_req.base_waddr = r_pos[AW-1:0];
                    o_req.base_wdata = i_element_value;
                    if (r_pos != PW'(CELLS)) begin
                        n_pos = r_pos + PW'(1);
                    end
                    if (i_last_element) begin
                        n_pos   = '0;
                        n_exp   = i_exponent;
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_INIT;
                    end
                end
            end
            // identity into the accumulated matrix
            S_INIT: begin
                o_req.acc_we    = 1'b1;
                o_req.acc_waddr = cell_addr(r_i, r_j, dim_n);
                o_req.acc_wdata = (r_i == r_j) ? ELEM_WIDTH'(1) : '0;
                n_j = j_end ? '0 : r_j + IW'(1);
                if (j_end) begin
                    n_i = i_end ? '0 : r_i + IW'(1);
                    if (i_end) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
                if (r_exp == '0) begin
                    n_state = S_OUT_RD;
                end else begin
                    n_mode  = r_exp[0] ? M_MUL : M_SQ;
                    n_state = S_MUL;
                end
            end
            // issue one multiply-accumulate per cycle, k innermost
            S_MUL: begin
                o_req.base_ra0 = cell_addr(r_i, r_k, dim_n);
                o_req.acc_ra   = cell_addr(r_i, r_k, dim_n);
                o_req.base_ra1 = cell_addr(r_k, r_j, dim_n);
                n_p1.v     = 1'b1;
                n_p1.first = (r_k == '0);
                n_p1.last  = k_end;
                n_p1.dest  = cell_addr(r_i, r_j, dim_n);
                n_k = k_end ? '0 : r_k + IW'(1);
                if (k_end) begin
                    n_j = j_end ? '0 : r_j + IW'(1);
                    if (j_end) begin
                        n_i = i_end ? '0 : r_i + IW'(1);
                        if (i_end) begin
                            n_state = S_MDRAIN;
                        end
                    end
                end
            end
            S_MDRAIN: begin
                if (!r_p1.v && !r_p2.v) begin
                    n_state = S_COPY;
                end
            end
            // scratch back into its target, written in the cycle after the read
            S_COPY: begin
                o_req.scr_ra = cell_addr(r_i, r_j, dim_n);
                n_cp_v    = 1'b1;
                n_cp_addr = cell_addr(r_i, r_j, dim_n);
                n_j = j_end ? '0 : r_j + IW'(1);
                if (j_end) begin
                    n_i = i_end ? '0 : r_i + IW'(1);
                    if (i_end) begin
                        n_state = S_CPDRAIN;
                    end
                end
            end
            S_CPDRAIN: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
                if (r_mode == M_MUL) begin
                    n_mode  = M_SQ;
                    n_state = S_MUL;
                end else begin
                    n_exp   = r_exp >> 1;
                    n_state = S_CHECK;
                end
            end
            S_OUT_RD: begin
                o_req.acc_ra = cell_addr(r_i, r_j, dim_n);
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_ovalid = 1'b1;
                n_state  = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_ready) begin
                    n_ovalid = 1'b0;
                    n_j = j_end ? '0 : r_j + IW'(1);
                    if (j_end) begin
                        n_i = i_end ? '0 : r_i + IW'(1);
                    end
                    n_state = (i_end && j_end) ? S_LOAD : S_OUT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase

        // copy write lands in accumulated or base matrix
        if (r_cp_v) begin
            if (r_mode == M_MUL) begin
                o_req.acc_we    = 1'b1;
                o_req.acc_waddr = r_cp_addr;
                o_req.acc_wdata = i_rsp.scr_rd;
            end else begin
                o_req.base_we    = 1'b1;
                o_req.base_waddr = r_cp_addr;
                o_req.base_wdata = i_rsp.scr_rd;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_result_value = r_oval;
    assign o_last_result  = r_olast;

    // scratch is written only by the product pipe
    a_scr_wr_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2.v |-> (r_state == S_MUL || r_state == S_MDRAIN))
        else $error("scratch write outside multiply");

    // no input request while a result is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input ready while result pending");

    // exponent shifts by one bit after each square
    a_exp_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CPDRAIN && r_mode == M_SQ) |=> (r_exp == ($past(r_exp) >> 1)))
        else $error("exponent step wrong");

endmodule

// ===== rtl/matrix_power_by_squaring_core.sv =====
// Flow: one loaded element per cycle while in the load state; after the last element the
//   core writes the identity, then per exponent bit runs 1 or 2 products (multiply, drain,
//   copy back), then for each result element reads, loads and holds it until it is taken.
// Throughput: one matrix at a time, set by the single shared 32x32 multiplier.
// Reset: synchronous active low; clears control and sets dimension to 4.
//   The matrix memories are not cleared.
module matrix_power_by_squaring_core import mpsq_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_W-1:0]             i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [ELEM_WIDTH-1:0] i_element_value,
    input  logic [EXP_W-1:0]             i_exponent,
    input  logic                         i_last_element,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [ELEM_WIDTH-1:0] o_result_value,
    output logic                         o_last_result
);

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    mpsq_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_element_value (i_element_value),
        .i_exponent      (i_exponent),
        .i_last_element  (i_last_element),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_value  (o_result_value),
        .o_last_result   (o_last_result),
        .o_req           (mem_req),
        .i_rsp           (mem_rsp)
    );

    mpsq_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

endmodule
